>>> rtl/core/longest_nondecreasing_subsequence_assert.svh
// Assertion macros used by the checker file of the subsequence block.
`ifndef LONGEST_NONDECREASING_SUBSEQUENCE_ASSERT_SVH
`define LONGEST_NONDECREASING_SUBSEQUENCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LNDS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LNDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/lnds_pkg.sv
// Shared constants and types of the longest non-decreasing subsequence block.
package lnds_pkg;

    localparam int MAX_ITEMS_DEF = 256;
    localparam int VALUE_W       = 32;
    localparam int LEN_OUT_W     = 9;
    localparam int LEN_OUT_MAX   = (2 ** LEN_OUT_W) - 1;

    // Control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic rd_vld;
    } t_scan_ctl;

endpackage

>>> rtl/core/longest_nondecreasing_subsequence.sv
// Longest non-decreasing subsequence length over a stream of signed 32-bit words.
// Each accepted word is compared against every word stored earlier in the current
// sequence, one stored word per cycle through the single read port of the store,
// and the input stays stalled until the block is idle again; the first word of
// a sequence and a word dropped because the store is full skip the scan.
// A word marked last then passes through an emit state that hands the length and
// overflow flag to the output register, waiting while the previous result word is
// still stalled there; the register then holds them until taken while the next
// sequence starts, and the block clears itself after each result. Up to MAX_ITEMS
// words are stored per sequence; further words are dropped and raise the overflow
// flag.
module longest_nondecreasing_subsequence #(
    parameter int MAX_ITEMS = lnds_pkg::MAX_ITEMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lnds_pkg::VALUE_W-1:0] i_element_value,
    input  logic                                i_is_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lnds_pkg::LEN_OUT_W-1:0]      o_longest_length,
    output logic                                o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = (CW > lnds_pkg::LEN_OUT_W) ? CW : lnds_pkg::LEN_OUT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_STORE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                              r_state, n_state;
    logic [CW-1:0]                       r_count, n_count;
    logic [CW-1:0]                       r_best, n_best;
    logic                                r_dropped, n_dropped;
    logic [AW-1:0]                       r_rd_addr, n_rd_addr;
    logic signed [lnds_pkg::VALUE_W-1:0] r_key;
    logic                                r_last;
    logic                                r_drop, n_drop;
    logic                                r_out_valid, n_out_valid;
    logic [lnds_pkg::LEN_OUT_W-1:0]      r_out_len;
    logic                                r_out_ovf;

    logic                                in_acc;
    logic                                out_free;
    logic                                rd_en;
    logic                                wr_en;
    logic                                load_out;
    logic                                mem_rd_vld;
    logic signed [lnds_pkg::VALUE_W-1:0] mem_rd_value;
    logic [CW-1:0]                       mem_rd_len;
    logic [CW-1:0]                       cur_len;
    lnds_pkg::t_scan_ctl                 scan_ctl;
    logic [XW-1:0]                       best_x;
    logic [lnds_pkg::LEN_OUT_W-1:0]      best_sat;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Saturate the running maximum to the output field
    assign best_x   = XW'(r_best);
    assign best_sat = (best_x > XW'(lnds_pkg::LEN_OUT_MAX)) ?
                      lnds_pkg::LEN_OUT_W'(lnds_pkg::LEN_OUT_MAX) :
                      best_x[lnds_pkg::LEN_OUT_W-1:0];

    // Sequence one word: scan, store or drop it, update the maximum, emit on last
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_best      = r_best;
        n_dropped   = r_dropped;
        n_rd_addr   = r_rd_addr;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && i_out_stall;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rd_addr = '0;
                    n_drop    = (r_count == CW'(MAX_ITEMS));
                    if ((r_count == CW'(MAX_ITEMS)) || (r_count == '0)) begin
                        n_state = S_STORE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_en = 1'b1;
                if (CW'(r_rd_addr) == (r_count - CW'(1))) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_addr = r_rd_addr + AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                if (r_drop) begin
                    n_dropped = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                    if (cur_len > r_best) begin
                        n_best = cur_len;
                    end
                end
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_best      = '0;
                    n_dropped   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_best      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_best      <= n_best;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the word under work and the scan address
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_drop    <= n_drop;
        if (in_acc) begin
            r_key  <= i_element_value;
            r_last <= i_is_last;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_len <= best_sat;
            r_out_ovf <= r_dropped;
        end
    end

    assign scan_ctl.clear  = in_acc;
    assign scan_ctl.rd_vld = mem_rd_vld;

    lnds_mem #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .LW        (CW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_count[AW-1:0]),
        .i_wr_value (r_key),
        .i_wr_len   (cur_len),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_rd_addr),
        .o_rd_vld   (mem_rd_vld),
        .o_rd_value (mem_rd_value),
        .o_rd_len   (mem_rd_len)
    );

    lnds_cmp #(
        .LW (CW)
    ) u_cmp (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_key      (r_key),
        .i_rd_value (mem_rd_value),
        .i_rd_len   (mem_rd_len),
        .o_len      (cur_len)
    );

    assign o_out_valid      = r_out_valid;
    assign o_longest_length = r_out_len;
    assign o_overflow       = r_out_ovf;

endmodule

>>> rtl/core/lnds_mem.sv
// Value and chain length store with one write port and one registered read port.
module lnds_mem #(
    parameter int MAX_ITEMS = lnds_pkg::MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int LW        = $clog2(MAX_ITEMS + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [AW-1:0]                      i_wr_addr,
    input  logic signed [lnds_pkg::VALUE_W-1:0] i_wr_value,
    input  logic [LW-1:0]                      i_wr_len,
    input  logic                               i_rd_en,
    input  logic [AW-1:0]                      i_rd_addr,
    output logic                               o_rd_vld,
    output logic signed [lnds_pkg::VALUE_W-1:0] o_rd_value,
    output logic [LW-1:0]                      o_rd_len
);

    logic signed [lnds_pkg::VALUE_W-1:0] r_value_mem [MAX_ITEMS];
    logic [LW-1:0]                       r_len_mem   [MAX_ITEMS];
    logic                                r_rd_vld;

    // Write the new element
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_value_mem[i_wr_addr] <= i_wr_value;
            r_len_mem[i_wr_addr]   <= i_wr_len;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_value <= r_value_mem[i_rd_addr];
            o_rd_len   <= r_len_mem[i_rd_addr];
        end
    end

    // Track which cycles carry fresh read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
        end
    end

    assign o_rd_vld = r_rd_vld;

endmodule

>>> rtl/core/lnds_cmp.sv
// Shared compare and increment unit that builds one element's chain length.
module lnds_cmp #(
    parameter int LW = $clog2(lnds_pkg::MAX_ITEMS_DEF + 1)
) (
    input  logic                               i_clk,
    input  lnds_pkg::t_scan_ctl                i_ctl,
    input  logic signed [lnds_pkg::VALUE_W-1:0] i_key,
    input  logic signed [lnds_pkg::VALUE_W-1:0] i_rd_value,
    input  logic [LW-1:0]                      i_rd_len,
    output logic [LW-1:0]                      o_len
);

    logic [LW-1:0] r_len;
    logic [LW:0]   cand;
    logic          take;

    // Candidate length through the stored element
    assign cand = {1'b0, i_rd_len} + (LW + 1)'(1);
    assign take = i_ctl.rd_vld && (i_rd_value <= i_key) && (cand > {1'b0, r_len});

    // Restart at one, then keep the best candidate
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_len <= LW'(1);
        end else if (take) begin
            r_len <= cand[LW-1:0];
        end
    end

    assign o_len = r_len;

endmodule

>>> rtl/core/lnds_chk.sv
// Port-level checker for the subsequence block, bound to the top level.
`include "longest_nondecreasing_subsequence_assert.svh"

module lnds_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [lnds_pkg::LEN_OUT_W-1:0] o_longest_length,
    input logic                           o_overflow
);

    logic                         in_take;
    logic                         out_wait;
    logic [lnds_pkg::LEN_OUT_W:0] out_word;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_wait = o_out_valid && i_out_stall;
    assign out_word = {o_longest_length, o_overflow};

    // One word at a time: busy right after a word is taken
    `LNDS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, o_in_stall)

    // A stalled result word holds
    `LNDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(out_word))

    // Every sequence stores its first word, so a result is never zero
    `LNDS_ASSERT_SAME(a_len_nonzero, i_clk, i_rst_n, o_out_valid, o_longest_length != '0)

endmodule

bind longest_nondecreasing_subsequence lnds_chk u_lnds_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_longest_length (o_longest_length),
    .o_overflow       (o_overflow)
);

>>> tb/sv/longest_nondecreasing_subsequence_test.sv
// Self-checking testbench for the longest non-decreasing subsequence block.
`timescale 1ns / 100ps

module longest_nondecreasing_subsequence_test;

    localparam int CAPACITY    = lnds_pkg::MAX_ITEMS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = CAPACITY + 40;

    typedef struct packed {
        logic [lnds_pkg::LEN_OUT_W-1:0] length;
        logic                           overflow;
    } t_lnds_result;

    logic                                i_clk            = 1'b0;
    logic                                i_rst_n          = 1'b0;
    logic                                i_in_valid       = 1'b0;
    logic                                o_in_stall;
    logic signed [lnds_pkg::VALUE_W-1:0] i_element_value  = '0;
    logic                                i_is_last        = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall      = 1'b0;
    logic [lnds_pkg::LEN_OUT_W-1:0]      o_longest_length;
    logic                                o_overflow;

    // Predictor state: stored words and their chain lengths
    logic signed [lnds_pkg::VALUE_W-1:0] seen_values [CAPACITY];
    int                                  chain_lens  [CAPACITY];
    int                                  seen_count  = 0;
    int                                  best_chain  = 0;
    logic                                words_dropped = 1'b0;

    t_lnds_result              pending_lengths [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    longest_nondecreasing_subsequence u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_element_value  (i_element_value),
        .i_is_last        (i_is_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_longest_length (o_longest_length),
        .o_overflow       (o_overflow)
    );

    // Toggle the clock every half period
    always #5 i_clk = ~i_clk;

    // Stop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive the output stall at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Update the chain lengths for one accepted word; queue the length on a last word
    function automatic void predict_chain(
        input logic signed [lnds_pkg::VALUE_W-1:0] word_value,
        input logic last_word);
        int           chain;
        t_lnds_result res;
        if (seen_count < CAPACITY) begin
            chain = 1;
            for (int j = 0; j < seen_count; j++) begin
                if (seen_values[j] <= word_value && chain_lens[j] + 1 > chain) begin
                    chain = chain_lens[j] + 1;
                end
            end
            seen_values[seen_count] = word_value;
            chain_lens[seen_count]  = chain;
            seen_count++;
            if (chain > best_chain) begin
                best_chain = chain;
            end
        end else begin
            words_dropped = 1'b1;
        end
        if (last_word) begin
            res.length   = (best_chain > lnds_pkg::LEN_OUT_MAX) ?
                           lnds_pkg::LEN_OUT_W'(lnds_pkg::LEN_OUT_MAX) :
                           best_chain[lnds_pkg::LEN_OUT_W-1:0];
            res.overflow = words_dropped;
            pending_lengths.push_back(res);
            seen_count    = 0;
            best_chain    = 0;
            words_dropped = 1'b0;
        end
    endfunction

    // Pick a word: small values for ties, wide random, extremes, or a middle range
    function automatic logic signed [lnds_pkg::VALUE_W-1:0] pick_value();
        logic signed [lnds_pkg::VALUE_W-1:0] v;
        case ($urandom_range(3))
            0: v = int'($urandom_range(8)) - 4;
            1: v = $urandom;
            2: begin
                case ($urandom_range(3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(2000)) - 1000;
        endcase
        return v;
    endfunction

    // Send one word; called and returns at a falling edge
    task automatic send_word(input logic signed [lnds_pkg::VALUE_W-1:0] word_value,
                             input logic last_word);
        // Idle the sender cycle by cycle at the given rate
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_element_value <= word_value;
        i_is_last       <= last_word;
        do @(posedge i_clk); while (o_in_stall);
        predict_chain(word_value, last_word);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Compare each result taken with the oldest expected one
    always @(posedge i_clk) begin
        t_lnds_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_lengths.size() == 0) begin
                $error("result with no expectation: longest_length %0d overflow %0d",
                       o_longest_length, o_overflow);
                error_count++;
            end else begin
                exp_res = pending_lengths.pop_front();
                results_checked++;
                if (o_longest_length !== exp_res.length) begin
                    $error("longest_length expected %0d actual %0d",
                           exp_res.length, o_longest_length);
                    error_count++;
                end
                if (o_overflow !== exp_res.overflow) begin
                    $error("overflow expected %0d actual %0d",
                           exp_res.overflow, o_overflow);
                    error_count++;
                end
            end
        end
    end

    // Single words, a pair and a four-word sequence at and between the value extremes
    task automatic test_extremes();
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh7fff_ffff, 1'b1);
        send_word(32'sh7fff_ffff, 1'b0);
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh8000_0000, 1'b0);
        send_word(-1, 1'b0);
        send_word(0, 1'b0);
        send_word(32'sh7fff_ffff, 1'b1);
    endtask

    // An equal run, a strictly falling run and a mixed order
    task automatic test_ties_and_order();
        repeat (4) send_word(7, 1'b0);
        send_word(7, 1'b1);
        for (int k = 5; k >= 1; k--) begin
            send_word(k, k == 1);
        end
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(-1, 1'b0);
        send_word(2, 1'b1);
    endtask

    // Hold the sender until every length has come, then start a new sequence
    task automatic test_drain_pause();
        send_word(3, 1'b0);
        send_word(3, 1'b1);
        i_in_valid <= 1'b0;
        wait (pending_lengths.size() == 0);
        @(negedge i_clk);
        send_word(-3, 1'b0);
        send_word(9, 1'b1);
    endtask

    // Fill the store with a non-decreasing run, then drop two words, the last one marked
    task automatic test_full_store_overflow();
        logic signed [lnds_pkg::VALUE_W-1:0] v;
        v = -1000;
        for (int k = 0; k < CAPACITY; k++) begin
            send_word(v, 1'b0);
            v = v + int'($urandom_range(3));
        end
        send_word(pick_value(), 1'b0);
        send_word(pick_value(), 1'b1);
    endtask

    // Random sequences, mostly short, under the given idling
    task automatic test_random_sequences(input int idle_pct, input int stall_pct,
                                         input int word_target);
        int seq_len;
        int start_count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = words_sent;
        while (words_sent - start_count < word_target) begin
            seq_len = ($urandom_range(7) == 0) ? $urandom_range(16, 40)
                                               : $urandom_range(1, 12);
            for (int k = 0; k < seq_len; k++) begin
                send_word(pick_value(), k == seq_len - 1);
            end
        end
    endtask

    initial begin
        // Hold reset, then release at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_ties_and_order();
        test_drain_pause();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        test_full_store_overflow();
        test_random_sequences(0, 0, 50);
        test_random_sequences(57, 0, 50);
        test_random_sequences(0, 57, 50);
        test_random_sequences(16, 16, 50);

        // Drain the remaining lengths and watch for stray results
        i_in_valid <= 1'b0;
        wait (pending_lengths.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d words incl. full and overflowing sequences; checked %0d lengths",
                 words_sent, results_checked);
        $display("idling phases: none, sender, receiver, both; %0d cycles", cycle_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> longest_nondecreasing_subsequence.f
+incdir+rtl/core
rtl/core/lnds_pkg.sv
rtl/core/lnds_mem.sv
rtl/core/lnds_cmp.sv
rtl/core/longest_nondecreasing_subsequence.sv
rtl/core/lnds_chk.sv
tb/sv/longest_nondecreasing_subsequence_test.sv
